### rtl/interval_range_map_macros.svh
// Assertion macros for the interval range map.
`ifndef INTERVAL_RANGE_MAP_MACROS_SVH
`define INTERVAL_RANGE_MAP_MACROS_SVH

`ifndef SYNTHESIS
`define IRM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval_range_map: check failed");
`define IRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval_range_map: check failed");
`else
`define IRM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define IRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/irm_pkg.sv
package irm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 8;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_ASSIGN = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } irm_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EVAL,
    S_MOVE
  } irm_state_t;

  typedef struct packed {
    logic                  req_type;
    logic [KEY_BITS-1:0]   key_low;
    logic [KEY_BITS-1:0]   key_high;
    logic [VALUE_BITS-1:0] new_value;
  } irm_req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic [1:0]            status;
    logic [4:0]            entry_count;
  } irm_result_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } irm_entry_t;

  typedef struct packed {
    logic lt_lo;
    logic le_lo;
    logic le_hi;
  } irm_flags_t;

  // What each cell reports when it holds the last entry of a compare run.
  typedef struct packed {
    logic [CNT_W-1:0]      lo_end;
    logic [CNT_W-1:0]      hi_end;
    logic [VALUE_BITS-1:0] hi_value;
    logic [VALUE_BITS-1:0] look_value;
  } irm_tap_t;

  typedef struct packed {
    logic                  init;
    logic [VALUE_BITS-1:0] init_value;
    logic [CNT_W-1:0]      count;
    logic [KEY_BITS-1:0]   key_low;
    logic [KEY_BITS-1:0]   key_high;
    logic                  shift_right;
    logic                  shift_left;
    logic [CNT_W-1:0]      bound;
    logic                  write;
    logic [CNT_W-1:0]      lo_pos;
    logic [CNT_W-1:0]      hi_pos;
    logic [VALUE_BITS-1:0] new_value;
    logic [VALUE_BITS-1:0] hi_value;
  } irm_ctl_t;

endpackage

### rtl/irm_cell.sv
module irm_cell
  import irm_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  irm_ctl_t         ctl,
  input  irm_entry_t       left_entry,
  input  irm_entry_t       right_entry,
  input  irm_flags_t       right_flags,
  output irm_entry_t       entry,
  output irm_flags_t       flags,
  output irm_tap_t         tap
);

  logic [CNT_W-1:0] pos;
  logic             valid;
  logic             last_lt_lo;
  logic             last_le_lo;
  logic             last_le_hi;
  irm_entry_t       entry_r;
  irm_entry_t       entry_nxt;

  assign pos   = CNT_W'(idx);
  assign valid = pos < ctl.count;
  assign entry = entry_r;

  assign flags.lt_lo = valid && (entry_r.key < ctl.key_low);
  assign flags.le_lo = valid && (entry_r.key <= ctl.key_low);
  assign flags.le_hi = valid && (entry_r.key <= ctl.key_high);

  // The valid keys are sorted, so each flag is a run from cell zero.
  assign last_lt_lo = flags.lt_lo && !right_flags.lt_lo;
  assign last_le_lo = flags.le_lo && !right_flags.le_lo;
  assign last_le_hi = flags.le_hi && !right_flags.le_hi;

  assign tap.lo_end     = last_lt_lo ? pos + CNT_W'(1) : '0;
  assign tap.hi_end     = last_le_hi ? pos + CNT_W'(1) : '0;
  assign tap.hi_value   = last_le_hi ? entry_r.value : '0;
  assign tap.look_value = last_le_lo ? entry_r.value : '0;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.init) begin
      entry_nxt.key   = '0;
      entry_nxt.value = ctl.init_value;
    end else if (ctl.write && pos == ctl.lo_pos) begin
      entry_nxt.key   = ctl.key_low;
      entry_nxt.value = ctl.new_value;
    end else if (ctl.write && pos == ctl.hi_pos) begin
      entry_nxt.key   = ctl.key_high;
      entry_nxt.value = ctl.hi_value;
    end else if (ctl.shift_right && pos > ctl.bound) begin
      entry_nxt = left_entry;
    end else if (ctl.shift_left && pos >= ctl.bound) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### rtl/interval_range_map.sv
// Interval range map: a row of breakpoint cells that compare in parallel and shift by one
// place per cycle. Lookups, empty and rejected assigns pass S_CMP and S_EVAL to a registered
// result strobe. A completed assign also moves the entries above key_high |m - 2| places,
// m being the breakpoints in [key_low, key_high]; the next transaction is accepted in the
// cycle of the strobe. The receiver cannot stall. Synchronous reset (rst_n low) leaves one
// breakpoint (0, 0); a write of the default value reinitialises the table.
`include "interval_range_map_macros.svh"

module interval_range_map
  import irm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  irm_req_t              in_req,
  output logic                  out_valid,
  output irm_result_t           out_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [VALUE_BITS-1:0] cfg_default_value
);

  irm_state_t            state_r, state_nxt;
  irm_req_t              req_r, req_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      n_lo_r, n_lo_nxt;
  logic [CNT_W-1:0]      n_le_hi_r, n_le_hi_nxt;
  logic [VALUE_BITS-1:0] hi_val_r, hi_val_nxt;
  logic [VALUE_BITS-1:0] look_val_r, look_val_nxt;
  logic [CNT_W-1:0]      target_r, target_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CNT_W-1:0]      cur_r, cur_nxt;
  logic                  out_valid_r, out_valid_nxt;
  irm_result_t           out_result_r, out_result_nxt;

  irm_ctl_t              ctl;
  irm_entry_t            entries [TABLE_DEPTH];
  irm_flags_t            flags   [TABLE_DEPTH];
  irm_tap_t              taps    [TABLE_DEPTH];
  irm_tap_t              tap_any;
  logic                  cfg_fire;
  logic [CNT_W:0]        total_w;

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      irm_entry_t left_e;
      irm_entry_t right_e;
      irm_flags_t right_f;
      if (g == 0) begin : g_first
        assign left_e = '0;
      end else begin : g_inner_l
        assign left_e = entries[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_last
        assign right_e = '0;
        assign right_f = '0;
      end else begin : g_inner_r
        assign right_e = entries[g+1];
        assign right_f = flags[g+1];
      end
      irm_cell u_cell (
        .clk         (clk),
        .idx         (IDX_W'(g)),
        .ctl         (ctl),
        .left_entry  (left_e),
        .right_entry (right_e),
        .right_flags (right_f),
        .entry       (entries[g]),
        .flags       (flags[g]),
        .tap         (taps[g])
      );
    end
  endgenerate

  // At most one cell reports each field, so an OR gathers them.
  always_comb begin
    tap_any = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tap_any = tap_any | taps[i];
    end
  end

  assign total_w = {1'b0, n_lo_r} + (CNT_W + 1)'(2) + {1'b0, count_r} - {1'b0, n_le_hi_r};

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    count_nxt      = count_r;
    n_lo_nxt       = n_lo_r;
    n_le_hi_nxt    = n_le_hi_r;
    hi_val_nxt     = hi_val_r;
    look_val_nxt   = look_val_r;
    target_nxt     = target_r;
    total_nxt      = total_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;

    ctl             = '0;
    ctl.init        = !rst_n || cfg_fire;
    ctl.init_value  = rst_n ? cfg_default_value : '0;
    ctl.count       = count_r;
    ctl.key_low     = req_r.key_low;
    ctl.key_high    = req_r.key_high;
    ctl.lo_pos      = n_lo_r;
    ctl.hi_pos      = n_lo_r + CNT_W'(1);
    ctl.new_value   = req_r.new_value;
    ctl.hi_value    = hi_val_r;

    if (cfg_fire) begin
      count_nxt = CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        n_lo_nxt     = tap_any.lo_end;
        n_le_hi_nxt  = tap_any.hi_end;
        hi_val_nxt   = tap_any.hi_value;
        look_val_nxt = tap_any.look_value;
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        out_result_nxt.read_value  = '0;
        out_result_nxt.entry_count = 5'(count_r);
        target_nxt = n_lo_r + CNT_W'(2);
        total_nxt  = total_w[CNT_W-1:0];
        cur_nxt    = n_le_hi_r;
        if (req_r.req_type == REQ_LOOKUP) begin
          out_result_nxt.read_value = look_val_r;
          out_result_nxt.status     = STAT_OK;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end else if (req_r.key_low >= req_r.key_high) begin
          out_result_nxt.status = STAT_EMPTY;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end else if (total_w > (CNT_W + 1)'(TABLE_DEPTH)) begin
          out_result_nxt.status = STAT_FULL;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        // Move the entries above key_high one place a cycle until they start
        // just after the two new breakpoints.
        if (cur_r < target_r) begin
          ctl.shift_right = 1'b1;
          ctl.bound       = cur_r;
          cur_nxt         = cur_r + CNT_W'(1);
        end else if (cur_r > target_r) begin
          ctl.shift_left = 1'b1;
          ctl.bound      = cur_r - CNT_W'(1);
          cur_nxt        = cur_r - CNT_W'(1);
        end else begin
          ctl.write                  = 1'b1;
          count_nxt                  = total_r;
          out_result_nxt.read_value  = '0;
          out_result_nxt.status      = STAT_OK;
          out_result_nxt.entry_count = 5'(total_r);
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    n_lo_r       <= n_lo_nxt;
    n_le_hi_r    <= n_le_hi_nxt;
    hi_val_r     <= hi_val_nxt;
    look_val_r   <= look_val_nxt;
    target_r     <= target_nxt;
    total_r      <= total_nxt;
    cur_r        <= cur_nxt;
    out_result_r <= out_result_nxt;
  end

  `IRM_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_r >= 1 && count_r <= TABLE_DEPTH)
  `IRM_ASSERT_NEXT(a_accept_to_cmp, clk, rst_n, start && !busy, state_r == S_CMP)
  `IRM_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid_r, state_r == S_IDLE)
  `IRM_ASSERT_SAME(a_move_target, clk, rst_n, state_r == S_MOVE, target_r <= TABLE_DEPTH && total_r <= TABLE_DEPTH)

endmodule

### test/tb_interval_range_map.sv
`timescale 1ns / 1ps

module tb_interval_range_map;
  import irm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 500;
  localparam int PRINT_LIMIT = 20;

  logic        clk;
  logic        rst_n;
  logic        start = 1'b0;
  logic        busy;
  irm_req_t    in_req = '0;
  logic        out_valid;
  irm_result_t out_result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [VALUE_BITS-1:0] cfg_default_value;

  interval_range_map u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req            (in_req),
    .out_valid         (out_valid),
    .out_result        (out_result),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_default_value (cfg_default_value)
  );

  // Breakpoint table as the testbench believes it to be.
  logic [KEY_BITS-1:0]   map_keys [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] map_vals [TABLE_DEPTH];
  int                    map_used;

  irm_req_t    pending_reqs[$];
  irm_result_t expected_results[$];
  logic [KEY_BITS-1:0] key_pool[$];

  int  queued_total = 0;
  int  results_seen = 0;
  int  err_count = 0;
  int  idle_pct = 0;
  int  cycle_count = 0;
  int  cfg_writes = 0;
  int  n_lookup = 0;
  int  n_ok = 0;
  int  n_full = 0;
  int  n_empty = 0;
  logic took_item = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    if (err_count < PRINT_LIMIT) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic void map_init(logic [VALUE_BITS-1:0] dflt);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      map_keys[i] = '0;
      map_vals[i] = '0;
    end
    map_vals[0] = dflt;
    map_used = 1;
  endfunction

  function automatic logic [VALUE_BITS-1:0] map_value_at(logic [KEY_BITS-1:0] k);
    logic [VALUE_BITS-1:0] v;
    v = map_vals[0];
    for (int i = 0; i < map_used; i++) begin
      if (map_keys[i] <= k) v = map_vals[i];
    end
    return v;
  endfunction

  // Applies one request to the table and returns the result it should produce.
  function automatic irm_result_t map_apply(irm_req_t r);
    logic [KEY_BITS-1:0]   nk [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] nv [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] hi_val;
    int below;
    int above;
    int n;
    irm_result_t res;
    res = '0;
    if (r.req_type == REQ_LOOKUP) begin
      res.read_value = map_value_at(r.key_low);
    end else if (r.key_low >= r.key_high) begin
      res.status = STAT_EMPTY;
    end else begin
      hi_val = map_value_at(r.key_high);
      below = 0;
      above = 0;
      for (int i = 0; i < map_used; i++) begin
        if (map_keys[i] < r.key_low) below++;
        else if (map_keys[i] > r.key_high) above++;
      end
      if (below + above + 2 > TABLE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        n = 0;
        for (int i = 0; i < map_used; i++) begin
          if (map_keys[i] < r.key_low) begin
            nk[n] = map_keys[i];
            nv[n] = map_vals[i];
            n++;
          end
        end
        nk[n] = r.key_low;
        nv[n] = r.new_value;
        nk[n+1] = r.key_high;
        nv[n+1] = hi_val;
        n += 2;
        for (int i = 0; i < map_used; i++) begin
          if (map_keys[i] > r.key_high) begin
            nk[n] = map_keys[i];
            nv[n] = map_vals[i];
            n++;
          end
        end
        for (int i = 0; i < n; i++) begin
          map_keys[i] = nk[i];
          map_vals[i] = nv[i];
        end
        map_used = n;
      end
    end
    res.entry_count = map_used[4:0];
    return res;
  endfunction

  function automatic irm_req_t make_req(logic kind, logic [KEY_BITS-1:0] lo,
                                        logic [KEY_BITS-1:0] hi, logic [VALUE_BITS-1:0] val);
    irm_req_t r;
    r.req_type  = kind;
    r.key_low   = lo;
    r.key_high  = hi;
    r.new_value = val;
    return r;
  endfunction

  task automatic queue_req(irm_req_t r);
    pending_reqs.push_back(r);
    queued_total++;
  endtask

  task automatic wait_drained();
    while (results_seen != queued_total) @(posedge clk);
  endtask

  // Mostly keys from a small pool so that breakpoints are hit exactly, intervals are
  // often narrow enough to fill the table, and some fully random keys for bit coverage.
  function automatic irm_req_t random_req();
    irm_req_t r;
    int sel;
    int lo_idx;
    int hi_idx;
    r.req_type  = 1'($urandom_range(1));
    r.new_value = VALUE_BITS'($urandom_range(255));
    sel = $urandom_range(99);
    lo_idx = $urandom_range(key_pool.size() - 1);
    if (sel < 60) begin
      hi_idx = lo_idx + $urandom_range(1, 3);
      if (hi_idx > key_pool.size() - 1) hi_idx = key_pool.size() - 1;
      r.key_low  = key_pool[lo_idx];
      r.key_high = key_pool[hi_idx];
    end else if (sel < 75) begin
      r.key_low  = key_pool[lo_idx];
      r.key_high = key_pool[$urandom_range(key_pool.size() - 1)];
    end else if (sel < 87) begin
      r.key_low  = key_pool[lo_idx] + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
      r.key_high = r.key_low + $urandom_range(1, 4);
    end else begin
      r.key_low  = $urandom;
      r.key_high = $urandom;
    end
    return r;
  endfunction

  task automatic run_phase(logic [VALUE_BITS-1:0] dflt, int pct);
    logic [KEY_BITS-1:0] k;
    // The block is idle here, so the default value may be rewritten.
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_default_value <= dflt;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    map_init(dflt);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;

    key_pool.delete();
    k = '0;
    key_pool.push_back(k);
    for (int i = 0; i < 22; i++) begin
      k += ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 32'h0800_0000);
      key_pool.push_back(k);
    end
    key_pool.push_back(32'hFFFF_FFFE);
    key_pool.push_back(32'hFFFF_FFFF);

    idle_pct = pct;
    repeat (PHASE_ITEMS) queue_req(random_req());
    wait_drained();
  endtask

  // Driver: offers the next pending request, holding it until the block takes it.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start  <= 1'b1;
        in_req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each strobed result, then predicts for a transaction taken now.
  irm_result_t want;
  always @(posedge clk) begin
    took_item <= 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result strobed with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_result.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0h want %0h",
                                      out_result.read_value, want.read_value));
          if (out_result.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_result.status, want.status));
          if (out_result.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      out_result.entry_count, want.entry_count));
        end
      end
      if (start && !busy) begin
        took_item <= 1'b1;
        want = map_apply(in_req);
        expected_results.push_back(want);
        if (in_req.req_type == REQ_LOOKUP) n_lookup++;
        else if (want.status == STAT_OK) n_ok++;
        else if (want.status == STAT_FULL) n_full++;
        else n_empty++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, queued_total - results_seen);
      $display("tb_interval_range_map: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_default_value = '0;
    map_init('0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset table with default value zero.
    queue_req(make_req(REQ_LOOKUP, 32'h0, 32'h0, 8'h00));
    queue_req(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    queue_req(make_req(REQ_ASSIGN, 32'd10, 32'd20, 8'hFF));
    queue_req(make_req(REQ_LOOKUP, 32'd9, 32'h0, 8'h00));
    queue_req(make_req(REQ_LOOKUP, 32'd10, 32'h0, 8'h00));
    queue_req(make_req(REQ_LOOKUP, 32'd19, 32'h0, 8'h00));
    queue_req(make_req(REQ_LOOKUP, 32'd20, 32'h0, 8'h00));
    // Empty intervals: reversed and zero-length.
    queue_req(make_req(REQ_ASSIGN, 32'd20, 32'd10, 8'h55));
    queue_req(make_req(REQ_ASSIGN, 32'd5, 32'd5, 8'h55));
    // An interval from key zero overwrites the first entry and swallows the others.
    queue_req(make_req(REQ_ASSIGN, 32'd0, 32'd100, 8'h11));
    // Same value next door is kept as a separate breakpoint.
    queue_req(make_req(REQ_ASSIGN, 32'd100, 32'd200, 8'h11));
    queue_req(make_req(REQ_ASSIGN, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'h80));
    queue_req(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'h00));
    queue_req(make_req(REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0, 8'h00));
    // Narrow intervals add two breakpoints each until the table overflows.
    for (int i = 0; i < 6; i++) begin
      queue_req(make_req(REQ_ASSIGN, 32'd1000 + 2 * i, 32'd1001 + 2 * i,
                         VALUE_BITS'(8'hC0 + i)));
    end
    queue_req(make_req(REQ_LOOKUP, 32'd1002, 32'h0, 8'h00));
    wait_drained();

    run_phase(8'hFF, 15);
    run_phase(VALUE_BITS'($urandom_range(1, 254)), 48);
    run_phase(8'h00, 0);

    repeat (20) @(posedge clk);
    while (expected_results.size() > 0) begin
      void'(expected_results.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("Checked %0d transactions: %0d lookups, assigns %0d ok, %0d full, %0d empty",
             results_seen, n_lookup, n_ok, n_full, n_empty);
    $display("Default value rewritten %0d times; %0d mismatches", cfg_writes, err_count);
    if (err_count == 0) begin
      $display("tb_interval_range_map: done, clean");
    end else begin
      $display("tb_interval_range_map: done, errors");
    end
    $finish;
  end

endmodule

### interval_range_map.f
+incdir+rtl
rtl/irm_pkg.sv
rtl/irm_cell.sv
rtl/interval_range_map.sv
test/tb_interval_range_map.sv
